/* design/fvdft_pkg.sv */
// Shared types and codes for the face vertex dedup fan triangulator.
`timescale 1ns / 1ps
package fvdft_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_POS    = 3'd1;
    localparam logic [2:0] ST_SHORT_FACE = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_HALTED     = 3'd4;

    // How the current item ends
    typedef enum logic [2:0] {
        K_HALTED,
        K_BAD,
        K_FULL,
        K_HIT,
        K_NEW
    } fvdft_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic        load;
        logic        start_scan;
        logic        scan_step;
        logic        hit_take;
        logic        write_new;
        logic        finish;
        fvdft_kind_t kind;
    } fvdft_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic halted;
        logic pos_bad;
        logic hit;
        logic miss;
        logic full;
        logic out_free;
    } fvdft_stat_t;

endpackage

/* design/fvdft_ram.sv */
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module fvdft_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/fvdft_ctrl.sv */
// Control state machine: load, evaluate, table scan, result delivery.
`timescale 1ns / 1ps
module fvdft_ctrl
    import fvdft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  fvdft_stat_t stat,
    output fvdft_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t      state_reg, state_next;
    fvdft_kind_t kind_reg, kind_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.kind       = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.halted)
                begin
                    kind_next  = K_HALTED;
                    state_next = S_FINISH;
                end
                else if (stat.pos_bad)
                begin
                    kind_next  = K_BAD;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    cmd.hit_take = 1'b1;
                    kind_next    = K_HIT;
                    state_next   = S_FINISH;
                end
                else if (stat.miss)
                begin
                    if (stat.full)
                    begin
                        kind_next = K_FULL;
                    end
                    else
                    begin
                        cmd.write_new = 1'b1;
                        kind_next     = K_NEW;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_HALTED;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

/* design/fvdft_dp.sv */
// Datapath: reference resolve, key table scan and insert, fan state, result register.
`timescale 1ns / 1ps
module fvdft_dp
    import fvdft_pkg::*;
#(
    parameter int TABLE_DEPTH    = 4096,
    parameter int MAX_ATTRIBUTES = 65535
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [103:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,
    input  fvdft_cmd_t   cmd,
    output fvdft_stat_t  stat
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = IW + 1;
    localparam int KW = 51;

    // Latched input item
    logic signed [16:0] rp_reg, rt_reg, rn_reg;
    logic [15:0]        pc_in_reg, tc_in_reg, nc_in_reg;
    logic               last_reg;

    // Resolved item
    logic signed [16:0] p_reg, t_reg, n_reg;
    logic               tv_reg, nv_reg;
    logic [KW-1:0]      key_reg;

    // Scan and table state
    logic [CW-1:0] scan_idx_reg, data_idx_reg, count_reg;
    logic          data_vld_reg;
    logic [IW-1:0] vidx_reg;
    logic          is_new_reg;
    logic [KW-1:0] rd_data;

    // Face and halt state
    logic [IW-1:0] first_reg, prev_reg;
    logic [1:0]    seen_reg;
    logic          halted_reg;

    // Output register
    logic          m_tvalid_reg;
    logic [95:0]   m_tdata_reg;

    // Count clamp and reference resolve
    function automatic logic [15:0] clamp_cnt(input logic [15:0] c);
        clamp_cnt = ({8'd0, c} > 24'(MAX_ATTRIBUTES)) ? 16'(MAX_ATTRIBUTES) : c;
    endfunction

    function automatic logic signed [16:0] resolve(input logic signed [16:0] r,
                                                   input logic [15:0] c);
        if (r > 17'sd0)
        begin
            resolve = r - 17'sd1;
        end
        else if (r < 17'sd0)
        begin
            resolve = $signed({1'b0, c}) + r;
        end
        else
        begin
            resolve = -17'sd1;
        end
    endfunction

    logic [15:0]        pc, tc, nc;
    logic signed [16:0] p_res, t_res, n_res;
    logic               p_ok, t_ok, n_ok;

    always_comb
    begin
        pc    = clamp_cnt(pc_in_reg);
        tc    = clamp_cnt(tc_in_reg);
        nc    = clamp_cnt(nc_in_reg);
        p_res = resolve(rp_reg, pc);
        t_res = resolve(rt_reg, tc);
        n_res = resolve(rn_reg, nc);
        p_ok  = !p_res[16] && (p_res[15:0] < pc);
        t_ok  = !t_res[16] && (t_res[15:0] < tc);
        n_ok  = !n_res[16] && (n_res[15:0] < nc);
    end

    // Status to the controller
    logic scan_issue;
    assign scan_issue    = scan_idx_reg < count_reg;
    assign stat.halted   = halted_reg;
    assign stat.pos_bad  = !p_ok;
    assign stat.hit      = data_vld_reg && (rd_data == key_reg);
    assign stat.miss     = !data_vld_reg && (scan_idx_reg == count_reg);
    assign stat.full     = count_reg == CW'(TABLE_DEPTH);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Key table
    fvdft_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.write_new),
        .waddr (count_reg[IW-1:0]),
        .wdata (key_reg),
        .raddr (scan_idx_reg[IW-1:0]),
        .rdata (rd_data)
    );

    // Input latch, resolved fields and scan pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rp_reg    <= $signed(s_tdata[16:0]);
            rt_reg    <= $signed(s_tdata[33:17]);
            rn_reg    <= $signed(s_tdata[50:34]);
            pc_in_reg <= s_tdata[66:51];
            tc_in_reg <= s_tdata[82:67];
            nc_in_reg <= s_tdata[98:83];
            last_reg  <= s_tlast;
        end
        if (cmd.start_scan)
        begin
            p_reg   <= p_res;
            t_reg   <= t_res;
            n_reg   <= n_res;
            tv_reg  <= t_ok;
            nv_reg  <= n_ok;
            key_reg <= {n_res, t_res, p_res};
        end
        if (cmd.scan_step)
        begin
            data_idx_reg <= scan_idx_reg;
        end
        if (cmd.hit_take)
        begin
            vidx_reg   <= data_idx_reg[IW-1:0];
            is_new_reg <= 1'b0;
        end
        if (cmd.write_new)
        begin
            vidx_reg   <= count_reg[IW-1:0];
            is_new_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            data_vld_reg <= 1'b0;
        end
        else if (cmd.start_scan)
        begin
            scan_idx_reg <= '0;
            data_vld_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            data_vld_reg <= scan_issue;
        end
    end

    // Result assembly
    logic [IW+11:0] vidx_wide, first_wide, prev_wide;
    logic [2:0]     res_status;
    logic [95:0]    res_data;
    logic           res_tri, res_short, res_halt;

    always_comb
    begin
        vidx_wide  = {12'd0, vidx_reg};
        first_wide = {12'd0, first_reg};
        prev_wide  = {12'd0, prev_reg};
        res_tri    = seen_reg >= 2'd2;
        res_short  = last_reg && (seen_reg < 2'd2);
        res_data   = '0;
        res_status = ST_OK;
        res_halt   = 1'b0;
        case (cmd.kind)
            K_HALTED: res_status = ST_HALTED;
            K_BAD:
            begin
                res_status = ST_BAD_POS;
                res_halt   = 1'b1;
            end
            K_FULL:
            begin
                res_status = ST_TABLE_FULL;
                res_halt   = 1'b1;
            end
            default:
            begin
                res_status      = res_short ? ST_SHORT_FACE : ST_OK;
                res_halt        = res_short;
                res_data[14:3]  = vidx_wide[11:0];
                res_data[15]    = is_new_reg;
                res_data[31:16] = p_reg[15:0];
                res_data[47:32] = tv_reg ? t_reg[15:0] : 16'd0;
                res_data[48]    = tv_reg;
                res_data[64:49] = nv_reg ? n_reg[15:0] : 16'd0;
                res_data[65]    = nv_reg;
                res_data[66]    = res_tri;
                res_data[78:67] = res_tri ? first_wide[11:0] : 12'd0;
                res_data[90:79] = res_tri ? prev_wide[11:0] : 12'd0;
            end
        endcase
        res_data[2:0] = res_status;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_tdata_reg <= res_data;
        end
    end

    // Control state: count, face tracking, halt, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            first_reg    <= '0;
            prev_reg     <= '0;
            seen_reg     <= 2'd0;
            halted_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                m_tvalid_reg <= 1'b1;
                if (res_halt)
                begin
                    halted_reg <= 1'b1;
                end
                if (cmd.kind == K_HIT || cmd.kind == K_NEW)
                begin
                    if (seen_reg == 2'd0)
                    begin
                        first_reg <= vidx_reg;
                    end
                    prev_reg <= vidx_reg;
                    if (last_reg)
                    begin
                        seen_reg <= 2'd0;
                    end
                    else if (seen_reg < 2'd2)
                    begin
                        seen_reg <= seen_reg + 2'd1;
                    end
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("unique vertex count above table depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> (count_reg < CW'(TABLE_DEPTH)))
        else $error("insert into full table");

    a_halted_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && halted_reg) |=> (m_tdata_reg[2:0] == ST_HALTED))
        else $error("halted block gave a non-halted result");

    a_tri_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[66]) |-> (m_tdata_reg[2:0] == ST_OK))
        else $error("triangle reported with error status");

endmodule

/* design/face_vertex_dedup_fan_triangulator_unit.sv */
// Top level of the face vertex dedup fan triangulator.
`timescale 1ns / 1ps
// One face-vertex reference enters per item and gives exactly one result item.
// The key table is a RAM with one write and one read port. It is scanned one
// entry per cycle in insertion order until a match or its end; on a miss the new
// key is then written. A halted block, or a bad position reference, answers
// without a table scan. The next item is accepted in the cycle after the result
// is loaded, and a result still waiting on m_tready holds off that load. An
// error halts the block until reset; each later item gets status 4. The table
// needs no clearing pass: only entries below the unique vertex count are read.
module face_vertex_dedup_fan_triangulator_unit
    import fvdft_pkg::*;
#(
    parameter int TABLE_DEPTH    = 4096,
    parameter int MAX_ATTRIBUTES = 65535
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // raw_position_ref, raw_texcoord_ref, raw_normal_ref, position_count,
    // texcoord_count, normal_count, zero pad
    input  logic [103:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, vertex_index, is_new, position_index, texcoord_index,
    // texcoord_valid, normal_index, normal_valid, triangle_valid,
    // triangle_first, triangle_second, zero pad
    output logic [95:0]  m_tdata
);

    fvdft_cmd_t  cmd;
    fvdft_stat_t stat;

    fvdft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fvdft_dp #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
